### hdl/mssr_pkg.sv
`default_nettype none

package mssr_pkg;

	localparam int OP_W    = 3;
	localparam int NODE_W  = 10;
	localparam int DIST_W  = 32;
	localparam int LANE_W  = 3;
	localparam int EIDX_W  = 13;
	localparam int DEG_W   = 6;
	localparam int TGT_W   = 10;
	localparam int WGT_W   = 16;
	localparam int SHIFT_W = 5;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_LOAD_ROW  = 3'd0;
	localparam op_t OP_LOAD_EDGE = 3'd1;
	localparam op_t OP_RELAX     = 3'd2;
	localparam op_t OP_CLEAR     = 3'd3;
	localparam op_t OP_READ      = 3'd4;

	localparam logic KIND_REQ  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [DIST_W-1:0]  INF_DIST        = '1;
	localparam logic [SHIFT_W-1:0] DELTA_SHIFT_RST = 5'd10;

	// results one relax may give
	localparam int RESULT_LIMIT = 32;
	localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

	typedef struct packed {
		logic [TGT_W-1:0] target;
		logic [WGT_W-1:0] weight;
	} edge_t;

	typedef struct packed {
		logic row_we;
		logic dist_we;
	} nm_we_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [DIST_W-1:0] distance;
		logic [LANE_W-1:0] lane;
	} cand_t;

	typedef struct packed {
		logic              kind;
		logic [NODE_W-1:0] node;
		logic [DIST_W-1:0] distance;
		logic [LANE_W-1:0] lane;
		logic [DIST_W-1:0] bucket;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

### hdl/mssr_node_mem.sv
`default_nettype none

module mssr_node_mem import mssr_pkg::*; #(
	parameter int NODES = 1024,
	parameter int LANES = 8,
	parameter int NAW   = 10,
	parameter int DGW   = 6
) (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [NAW-1:0]                rd_addr,
	output logic      [EIDX_W-1:0]             rd_start,
	output logic      [DGW-1:0]                rd_deg,
	output logic      [LANES-1:0][DIST_W-1:0]  rd_dist,
	input  wire nm_we_t                        we,
	input  wire logic [NAW-1:0]                wr_addr,
	input  wire logic [EIDX_W-1:0]             wr_start,
	input  wire logic [DGW-1:0]                wr_deg,
	input  wire logic [LANES-1:0][DIST_W-1:0]  wr_dist
);

	typedef struct packed {
		logic [EIDX_W-1:0]            start;
		logic [DGW-1:0]               deg;
		logic [LANES-1:0][DIST_W-1:0] dist_row;
	} row_t;

	row_t mem [NODES];
	row_t rd_q;

	always_ff @(posedge clk) begin
		if (we.row_we) begin
			mem[wr_addr].start <= wr_start;
			mem[wr_addr].deg   <= wr_deg;
		end
		if (we.dist_we) begin
			mem[wr_addr].dist_row <= wr_dist;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_start = rd_q.start;
	assign rd_deg   = rd_q.deg;
	assign rd_dist  = rd_q.dist_row;

endmodule

`default_nettype wire

### hdl/mssr_edge_mem.sv
`default_nettype none

module mssr_edge_mem import mssr_pkg::*; #(
	parameter int EDGES = 8192,
	parameter int EAW   = 13
) (
	input  wire logic           clk,
	input  wire logic           rd_en,
	input  wire logic [EAW-1:0] rd_addr,
	output edge_t               rd_data,
	input  wire logic           wr_en,
	input  wire logic [EAW-1:0] wr_addr,
	input  wire edge_t          wr_data
);

	edge_t mem [EDGES];
	edge_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

### hdl/mssr_result.sv
`default_nettype none

module mssr_result import mssr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [SHIFT_W-1:0] shift,
	input  wire logic               cand_v,
	input  wire cand_t              cand,
	input  wire logic               flush,
	input  wire logic               rd_v,
	input  wire cand_t              rd,
	output logic                    strobe,
	output res_t                    res
);

	// one request is held back until the next one or the end of the walk,
	// so the final one can carry last
	logic             strobe_q;
	logic             pend_v_q;
	logic [CNT_W-1:0] cnt_q;
	res_t             pend_q;
	res_t             res_q;
	logic             take;
	logic             emit_pend;

	assign take      = cand_v && (32'(cnt_q) < RESULT_LIMIT);
	assign emit_pend = pend_v_q && (take || flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			strobe_q <= rd_v || emit_pend;
			if (take) begin
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v) begin
			res_q <= '{kind: KIND_READ, node: rd.node, distance: rd.distance, lane: rd.lane,
				bucket: '0, last: 1'b1};
		end else if (emit_pend) begin
			res_q <= '{kind: pend_q.kind, node: pend_q.node, distance: pend_q.distance,
				lane: pend_q.lane, bucket: pend_q.bucket, last: flush};
		end
		if (take) begin
			pend_q <= '{kind: KIND_REQ, node: cand.node, distance: cand.distance,
				lane: cand.lane, bucket: cand.distance >> shift, last: 1'b0};
		end
	end

	assign strobe = strobe_q;
	assign res    = res_q;

`ifndef SYNTHESIS
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= RESULT_LIMIT)
		else $error("result count past limit");

	a_read_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v |-> !pend_v_q)
		else $error("read result while a walk result is pending");
`endif

endmodule

`default_nettype wire

### hdl/multi_source_sssp_relax_unit.sv
`default_nettype none

// Load row, load edge, clear node and unknown codes keep busy only for the execute state.
// Read distance: strobe in the cycle after busy falls.
// Relax: busy through execute and check without improvement, else also through walk and drain,
//   one edge memory read per cycle; each request is held until the next one or the end
//   of the walk, the last one strobes in the cycle after busy falls.
// Throughput: one item at a time. Reset: a clearing pass sets every distance to infinity,
//   with busy high. Results cannot be stalled: each strobe lasts one cycle.
module multi_source_sssp_relax_unit import mssr_pkg::*; #(
	parameter int NODES      = 1024,
	parameter int EDGES      = 8192,
	parameter int LANES      = 8,
	parameter int MAX_DEGREE = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [OP_W-1:0]    operation,
	input  wire logic [NODE_W-1:0]  node,
	input  wire logic [DIST_W-1:0]  dist_req,
	input  wire logic [LANE_W-1:0]  lane,
	input  wire logic [EIDX_W-1:0]  edge_index,
	input  wire logic [DEG_W-1:0]   degree,
	input  wire logic [TGT_W-1:0]   target,
	input  wire logic [WGT_W-1:0]   weight,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [SHIFT_W-1:0] cfg_data,
	output logic                    strobe,
	output logic                    kind,
	output logic      [NODE_W-1:0]  out_node,
	output logic      [DIST_W-1:0]  out_dist,
	output logic      [LANE_W-1:0]  out_lane,
	output logic      [DIST_W-1:0]  bucket,
	output logic                    last
);

	localparam int NAW = $clog2(NODES);
	localparam int EAW = $clog2(EDGES);
	localparam int LAW = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int DGW = $clog2(MAX_DEGREE + 1);

	localparam logic [31:0] NODES_L = 32'(NODES);
	localparam logic [31:0] EDGES_L = 32'(EDGES);
	localparam logic [31:0] LANES_L = 32'(LANES);
	localparam logic [31:0] MAXD_L  = 32'(MAX_DEGREE);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_WALK,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic [NAW-1:0] clr_q;
	logic [DGW-1:0] i_q;
	logic           v_s1;
	logic           v_s2;
	logic [SHIFT_W-1:0] shift_q;

	op_t               op_q;
	logic [NODE_W-1:0] node_q;
	logic [DIST_W-1:0] dreq_q;
	logic [LANE_W-1:0] lane_q;
	logic [EIDX_W-1:0] eidx_q;
	logic [DEG_W-1:0]  deg_q;
	logic [TGT_W-1:0]  tgt_q;
	logic [WGT_W-1:0]  wgt_q;
	logic [EIDX_W-1:0] row_start_q;
	logic [DGW-1:0]    n_q;
	logic [DIST_W-1:0] sum_s2;
	logic [TGT_W-1:0]  tgt_s2;

	// node memory port
	logic                         nm_rd_en;
	logic [NAW-1:0]               nm_rd_addr;
	logic [EIDX_W-1:0]            nm_rd_start;
	logic [DGW-1:0]               nm_rd_deg;
	logic [LANES-1:0][DIST_W-1:0] nm_rd_dist;
	nm_we_t                       nm_we;
	logic [NAW-1:0]               nm_wr_addr;
	logic [LANES-1:0][DIST_W-1:0] nm_wr_dist;
	logic [LANES-1:0][DIST_W-1:0] row_mod;

	// edge memory port
	logic           em_rd_en;
	logic [EAW-1:0] em_rd_addr;
	edge_t          em_rd_data;
	logic           em_we;
	logic [EAW-1:0] em_wr_addr;
	edge_t          em_wr_data;

	logic [31:0]       node32, lane32, eidx32, deg32, deg_sat32, e32, t32;
	logic              node_ok, lane_ok, eidx_ok, issue_ok, tgt_ok, improve;
	logic [NAW-1:0]    node_idx;
	logic [LAW-1:0]    lane_idx;
	logic [DIST_W-1:0] cur_dist;
	logic [DIST_W:0]   sum_w;
	logic [DIST_W-1:0] sum_sat;

	logic  cand_v, flush, rd_v;
	cand_t cand, rd;
	res_t  res;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign node32    = 32'(node_q);
	assign lane32    = 32'(lane_q);
	assign eidx32    = 32'(eidx_q);
	assign deg32     = 32'(deg_q);
	assign node_ok   = node32 < NODES_L;
	assign lane_ok   = lane32 < LANES_L;
	assign eidx_ok   = eidx32 < EDGES_L;
	assign node_idx  = node32[NAW-1:0];
	assign lane_idx  = lane32[LAW-1:0];
	assign deg_sat32 = (deg32 > MAXD_L) ? MAXD_L : deg32;

	assign e32      = 32'(row_start_q) + 32'(i_q);
	assign issue_ok = (i_q < n_q) && (e32 < EDGES_L);
	assign t32      = 32'(em_rd_data.target);
	assign tgt_ok   = t32 < NODES_L;

	assign sum_w   = {1'b0, dreq_q} + (DIST_W+1)'(em_rd_data.weight);
	assign sum_sat = sum_w[DIST_W] ? INF_DIST : sum_w[DIST_W-1:0];

	assign cur_dist = nm_rd_dist[lane_idx];
	assign improve  = dreq_q < cur_dist;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			row_mod[l] = (LAW'(l) == lane_idx) ? dreq_q : nm_rd_dist[l];
		end
	end

	always_comb begin
		nm_rd_en   = 1'b0;
		nm_rd_addr = node_idx;
		nm_we      = '0;
		nm_wr_addr = node_idx;
		nm_wr_dist = row_mod;
		em_rd_en   = 1'b0;
		em_we      = 1'b0;
		rd_v       = 1'b0;
		rd         = '{node: node_q, distance: INF_DIST, lane: lane_q};
		flush      = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				nm_we.dist_we = 1'b1;
				nm_wr_addr    = clr_q;
				nm_wr_dist    = '1;
			end
			ST_IDLE: begin
			end
			ST_EXEC: begin
				unique case (op_q)
					OP_LOAD_ROW: nm_we.row_we = node_ok;
					OP_LOAD_EDGE: em_we = eidx_ok;
					OP_CLEAR: begin
						nm_we.dist_we = node_ok;
						nm_wr_dist    = '1;
					end
					OP_RELAX: nm_rd_en = node_ok && lane_ok;
					OP_READ: begin
						nm_rd_en = node_ok && lane_ok;
						rd_v     = !(node_ok && lane_ok);
					end
					default: begin
					end
				endcase
			end
			ST_CHECK: begin
				if (op_q == OP_RELAX) begin
					nm_we.dist_we = improve;
				end else begin
					rd_v        = 1'b1;
					rd.distance = cur_dist;
				end
			end
			ST_WALK: em_rd_en = issue_ok;
			ST_DRAIN: flush = !v_s1 && !v_s2;
			default: begin
			end
		endcase
		// neighbor lookup for the edge read last cycle
		if (v_s1) begin
			nm_rd_en   = tgt_ok;
			nm_rd_addr = t32[NAW-1:0];
		end
	end

	assign em_rd_addr = e32[EAW-1:0];
	assign em_wr_addr = eidx32[EAW-1:0];
	assign em_wr_data = '{target: tgt_q, weight: wgt_q};

	assign cand_v = v_s2 && (sum_s2 < cur_dist);
	assign cand   = '{node: tgt_s2, distance: sum_s2, lane: lane_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			i_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			shift_q <= DELTA_SHIFT_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				shift_q <= cfg_data;
			end
			v_s1 <= (state_q == ST_WALK) && issue_ok;
			v_s2 <= v_s1 && tgt_ok;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NODES_L - 32'd1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if ((op_q == OP_RELAX || op_q == OP_READ) && node_ok && lane_ok) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHECK: begin
					i_q <= '0;
					if (op_q == OP_RELAX && improve) begin
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (i_q < n_q) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q   <= operation;
			node_q <= node;
			dreq_q <= dist_req;
			lane_q <= lane;
			eidx_q <= edge_index;
			deg_q  <= degree;
			tgt_q  <= target;
			wgt_q  <= weight;
		end
		if (state_q == ST_CHECK) begin
			row_start_q <= nm_rd_start;
			n_q         <= nm_rd_deg;
		end
		if (v_s1) begin
			sum_s2 <= sum_sat;
			tgt_s2 <= em_rd_data.target;
		end
	end

	mssr_node_mem #(
		.NODES (NODES),
		.LANES (LANES),
		.NAW   (NAW),
		.DGW   (DGW)
	) u_node_mem (
		.clk      (clk),
		.rd_en    (nm_rd_en),
		.rd_addr  (nm_rd_addr),
		.rd_start (nm_rd_start),
		.rd_deg   (nm_rd_deg),
		.rd_dist  (nm_rd_dist),
		.we       (nm_we),
		.wr_addr  (nm_wr_addr),
		.wr_start (eidx_q),
		.wr_deg   (deg_sat32[DGW-1:0]),
		.wr_dist  (nm_wr_dist)
	);

	mssr_edge_mem #(
		.EDGES (EDGES),
		.EAW   (EAW)
	) u_edge_mem (
		.clk     (clk),
		.rd_en   (em_rd_en),
		.rd_addr (em_rd_addr),
		.rd_data (em_rd_data),
		.wr_en   (em_we),
		.wr_addr (em_wr_addr),
		.wr_data (em_wr_data)
	);

	mssr_result u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift_q),
		.cand_v (cand_v),
		.cand   (cand),
		.flush  (flush),
		.rd_v   (rd_v),
		.rd     (rd),
		.strobe (strobe),
		.res    (res)
	);

	assign kind     = res.kind;
	assign out_node = res.node;
	assign out_dist = res.distance;
	assign out_lane = res.lane;
	assign bucket   = res.bucket;
	assign last     = res.last;

`ifndef SYNTHESIS
	// the walk is read-only, so a node read never meets a write
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(nm_rd_en && (nm_we.row_we || nm_we.dist_we)))
		else $error("node memory read and write in the same cycle");

	a_s2_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("neighbor stage valid without edge stage");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2))
		else $error("walk pipeline not empty in idle");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result transfer without work in progress");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
	import mssr_pkg::*;

	localparam int NODE_CNT    = 1024;
	localparam int EDGE_CNT    = 8192;
	localparam int LANE_CNT    = 8;
	localparam int MAX_DEG     = 32;
	localparam int POOL_N      = 12;
	localparam int PHASE_ITEMS = 40;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [NODE_W-1:0] DIR_NODE = 10'd5;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] node;
		logic [DIST_W-1:0] dist_req;
		logic [LANE_W-1:0] lane;
		logic [EIDX_W-1:0] edge_index;
		logic [DEG_W-1:0]  degree;
		logic [TGT_W-1:0]  target;
		logic [WGT_W-1:0]  weight;
	} cmd_t;

	class relax_scoreboard;
		logic [DIST_W-1:0]  dist_mem [NODE_CNT*LANE_CNT];
		logic [EIDX_W-1:0]  row_first [NODE_CNT];
		logic [DEG_W-1:0]   row_cnt [NODE_CNT];
		bit                 row_set [NODE_CNT];
		logic [TGT_W-1:0]   edge_to [EDGE_CNT];
		logic [WGT_W-1:0]   edge_w [EDGE_CNT];
		bit                 edge_set [EDGE_CNT];
		logic [SHIFT_W-1:0] shift_amt;
		res_t               pending_out[$];
		res_t               fresh_reqs[$];
		int                 errors;

		function new();
			foreach (dist_mem[i])
				dist_mem[i] = INF_DIST;
			shift_amt = DELTA_SHIFT_RST;
			errors = 0;
		endfunction

		// a relax may only touch rows and edges that were loaded
		function bit row_usable(logic [NODE_W-1:0] n);
			int slot;
			if (!row_set[n])
				return 1'b0;
			for (int i = 0; i < row_cnt[n]; i++) begin
				slot = row_first[n] + i;
				if (slot < EDGE_CNT && !edge_set[slot])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void apply_cmd(cmd_t c);
			res_t              r;
			logic [DIST_W:0]   sum;
			logic [DIST_W-1:0] nd;
			logic [TGT_W-1:0]  t;
			int                slot;
			int                hits;
			fresh_reqs.delete();
			hits = 0;
			case (c.op)
				OP_LOAD_ROW: begin
					row_first[c.node] = c.edge_index;
					row_cnt[c.node] = (c.degree > MAX_DEG) ? DEG_W'(MAX_DEG) : c.degree;
					row_set[c.node] = 1'b1;
				end
				OP_LOAD_EDGE: begin
					edge_to[c.edge_index] = c.target;
					edge_w[c.edge_index] = c.weight;
					edge_set[c.edge_index] = 1'b1;
				end
				OP_CLEAR: begin
					for (int l = 0; l < LANE_CNT; l++)
						dist_mem[{c.node, LANE_W'(l)}] = INF_DIST;
				end
				OP_READ: begin
					r = '{KIND_READ, c.node, dist_mem[{c.node, c.lane}], c.lane, '0, 1'b1};
					pending_out.push_back(r);
				end
				OP_RELAX: begin
					if (c.dist_req < dist_mem[{c.node, c.lane}]) begin
						// store first: a self loop sees the new value
						dist_mem[{c.node, c.lane}] = c.dist_req;
						for (int i = 0; i < row_cnt[c.node] && hits < RESULT_LIMIT; i++) begin
							slot = row_first[c.node] + i;
							if (slot < EDGE_CNT) begin
								t = edge_to[slot];
								sum = c.dist_req + edge_w[slot];
								nd = sum[DIST_W] ? INF_DIST : sum[DIST_W-1:0];
								if (nd < dist_mem[{t, c.lane}]) begin
									r = '{KIND_REQ, t, nd, c.lane, nd >> shift_amt, 1'b0};
									fresh_reqs.push_back(r);
									hits++;
								end
							end
						end
						if (hits > 0)
							fresh_reqs[hits-1].last = 1'b1;
						foreach (fresh_reqs[k])
							pending_out.push_back(fresh_reqs[k]);
					end
				end
				default: ;
			endcase
		endfunction

		function void cmp_field(string name, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_out.size() == 0) begin
				$error("unexpected result: kind %0d node %0d dist %0h", got.kind, got.node,
					got.distance);
				errors++;
				return;
			end
			want = pending_out.pop_front();
			cmp_field("kind", want.kind, got.kind);
			cmp_field("out_node", want.node, got.node);
			cmp_field("out_dist", want.distance, got.distance);
			cmp_field("out_lane", want.lane, got.lane);
			cmp_field("bucket", want.bucket, got.bucket);
			cmp_field("last", want.last, got.last);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [OP_W-1:0]    operation = '0;
	logic [NODE_W-1:0]  node = '0;
	logic [DIST_W-1:0]  dist_req = '0;
	logic [LANE_W-1:0]  lane = '0;
	logic [EIDX_W-1:0]  edge_index = '0;
	logic [DEG_W-1:0]   degree = '0;
	logic [TGT_W-1:0]   target = '0;
	logic [WGT_W-1:0]   weight = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [SHIFT_W-1:0] cfg_data = '0;
	logic               strobe;
	logic               kind;
	logic [NODE_W-1:0]  out_node;
	logic [DIST_W-1:0]  out_dist;
	logic [LANE_W-1:0]  out_lane;
	logic [DIST_W-1:0]  bucket;
	logic               last;

	relax_scoreboard   sb;
	int                idle_pct = 0;
	int                items_sent = 0;
	int                cycle_cnt = 0;
	logic [NODE_W-1:0] pool [POOL_N];

	always #10 clk = ~clk;

	multi_source_sssp_relax_unit #(
		.NODES(NODE_CNT),
		.EDGES(EDGE_CNT),
		.LANES(LANE_CNT),
		.MAX_DEGREE(MAX_DEG)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.node(node),
		.dist_req(dist_req),
		.lane(lane),
		.edge_index(edge_index),
		.degree(degree),
		.target(target),
		.weight(weight),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.kind(kind),
		.out_node(out_node),
		.out_dist(out_dist),
		.out_lane(out_lane),
		.bucket(bucket),
		.last(last)
	);

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result({kind, out_node, out_dist, out_lane, bucket, last});
	end

	function automatic cmd_t mk(op_t op, logic [NODE_W-1:0] n, logic [DIST_W-1:0] d,
			logic [LANE_W-1:0] l, logic [EIDX_W-1:0] e, logic [DEG_W-1:0] g,
			logic [TGT_W-1:0] t, logic [WGT_W-1:0] w);
		return '{op, n, d, l, e, g, t, w};
	endfunction

	function automatic cmd_t rand_cmd();
		return mk(OP_READ, NODE_W'($urandom), $urandom, LANE_W'($urandom), EIDX_W'($urandom),
			DEG_W'($urandom), TGT_W'($urandom), WGT_W'($urandom));
	endfunction

	function automatic logic [DIST_W-1:0] pick_dist();
		case ($urandom_range(9))
			0: return '0;
			1: return INF_DIST;
			2, 3: return INF_DIST - $urandom_range(0, 70000);
			4, 5: return $urandom;
			default: return $urandom_range(0, 200000);
		endcase
	endfunction

	// drive one command and hold it until the transfer; start stays high afterwards
	task automatic send(cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= c.op;
		node <= c.node;
		dist_req <= c.dist_req;
		lane <= c.lane;
		edge_index <= c.edge_index;
		degree <= c.degree;
		target <= c.target;
		weight <= c.weight;
		do
			@(posedge clk);
		while (busy);
		sb.apply_cmd(c);
		if (c.op <= OP_READ)
			items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		repeat (4) @(posedge clk);
		while (busy || sb.pending_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_shift(logic [SHIFT_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.shift_amt = v;
	endtask

	// edges first, then the row, so a later relax walks only loaded slots
	task automatic build_row(logic [NODE_W-1:0] n);
		cmd_t c;
		int   base;
		int   len;
		base = ($urandom_range(7) == 0) ? $urandom_range(EDGE_CNT - 8, EDGE_CNT - 1)
			: $urandom_range(EDGE_CNT - 1);
		len = ($urandom_range(15) == 0) ? $urandom_range(MAX_DEG, (1 << DEG_W) - 1)
			: $urandom_range(0, 6);
		for (int i = 0; i < len && i < MAX_DEG; i++) begin
			if (base + i < EDGE_CNT) begin
				c = rand_cmd();
				c.op = OP_LOAD_EDGE;
				c.edge_index = EIDX_W'(base + i);
				if ($urandom_range(3) != 0)
					c.target = pool[$urandom_range(POOL_N - 1)];
				if ($urandom_range(3) != 0)
					c.weight = WGT_W'($urandom_range(0, 300));
				send(c);
			end
		end
		c = rand_cmd();
		c.op = OP_LOAD_ROW;
		c.node = n;
		c.edge_index = EIDX_W'(base);
		c.degree = DEG_W'(len);
		send(c);
	endtask

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		cmd_t c;
		res_t hop[$];
		int   goal;
		int   pick;
		sb = new();
		foreach (pool[p])
			pool[p] = NODE_W'($urandom);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_shift('0);

		// row at the top of the edge store: degree saturates, tail slots fall off the end
		send(mk(OP_READ, '1, '1, '1, '1, '1, '1, '1));
		for (int k = 0; k < 12; k++)
			send(mk(OP_LOAD_EDGE, '0, '0, '0, EIDX_W'(EDGE_CNT - 12 + k), '0,
				(k == 0) ? TGT_W'(0) : (k == 1) ? TGT_W'(NODE_CNT - 1)
				: (k == 2) ? TGT_W'(DIR_NODE) : TGT_W'(k + 4),
				(k == 1) ? {WGT_W{1'b1}} : WGT_W'(k)));
		send(mk(OP_LOAD_ROW, DIR_NODE, '1, '0, EIDX_W'(EDGE_CNT - 12), '1, '0, '0));
		send(mk(OP_RELAX, DIR_NODE, '0, '0, '0, '0, '0, '0));
		send(mk(OP_RELAX, DIR_NODE, INF_DIST - 15, '1, '0, '0, '0, '0));
		send(mk(OP_RELAX, DIR_NODE, '0, '0, '0, '0, '0, '0));
		send(mk(OP_RELAX, DIR_NODE, INF_DIST, LANE_W'(3), '0, '0, '0, '0));
		send(mk(OP_READ, DIR_NODE, '0, '1, '0, '0, '0, '0));
		send(mk(OP_CLEAR, DIR_NODE, '0, '0, '0, '0, '0, '0));
		send(mk(OP_READ, DIR_NODE, '0, '0, '0, '0, '0, '0));
		for (int u = OP_READ + 1; u < (1 << OP_W); u++)
			send(mk(op_t'(u), '1, '1, '1, '1, '1, '1, '1));
		// improves the entry but has no edges to walk
		send(mk(OP_LOAD_ROW, '0, '0, '0, '0, '0, '0, '0));
		send(mk(OP_RELAX, '0, '0, '0, '0, '0, '0, '0));
		send(mk(OP_READ, '0, '0, '0, '0, '0, '0, '0));

		for (int ph = 0; ph < 3; ph++) begin
			write_shift((ph == 0) ? '1 : (ph == 1) ? SHIFT_W'($urandom_range(1, 30))
				: SHIFT_W'($urandom));
			idle_pct = (ph == 0) ? 9 : (ph == 1) ? 60 : 0;
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				c = rand_cmd();
				pick = $urandom_range(99);
				if (pick < 35) begin
					// relax, then feed some emitted requests back like a worklist would
					c.op = OP_RELAX;
					c.node = pool[$urandom_range(POOL_N - 1)];
					c.dist_req = pick_dist();
					if (!sb.row_usable(c.node))
						build_row(c.node);
					send(c);
					hop = sb.fresh_reqs;
					foreach (hop[k]) begin
						if (k < 3 && $urandom_range(9) < 7 && sb.row_usable(hop[k].node)) begin
							c = rand_cmd();
							c.op = OP_RELAX;
							c.node = hop[k].node;
							c.dist_req = hop[k].distance;
							c.lane = hop[k].lane;
							send(c);
						end
					end
				end else if (pick < 50) begin
					build_row(pool[$urandom_range(POOL_N - 1)]);
				end else if (pick < 60) begin
					c.op = OP_CLEAR;
					if ($urandom_range(4) != 0)
						c.node = pool[$urandom_range(POOL_N - 1)];
					send(c);
				end else if (pick < 75) begin
					c.op = OP_READ;
					if ($urandom_range(1) != 0)
						c.node = pool[$urandom_range(POOL_N - 1)];
					send(c);
				end else if (pick < 85) begin
					c.op = OP_LOAD_EDGE;
					send(c);
				end else if (pick < 92) begin
					c.op = OP_LOAD_ROW;
					send(c);
				end else begin
					c.op = op_t'($urandom_range(OP_READ + 1, (1 << OP_W) - 1));
					send(c);
				end
			end
		end

		drain();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hdl/mssr_pkg.sv
hdl/mssr_node_mem.sv
hdl/mssr_edge_mem.sv
hdl/mssr_result.sv
hdl/multi_source_sssp_relax_unit.sv
tb/tb.sv
